/* hw/rtl/lkv_pkg.sv */
// Shared definitions for the LRU key-value cache: sizes, the entry record
// and the per-cell control record. No dependencies.
`default_nettype none

package lkv_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 32;
    localparam int CAP_W    = 5;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // One stored entry as it travels down the chain.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Per-cell control broadcast from the top level.
    typedef struct packed {
        logic go;        // an item is being applied this cycle
        logic put_miss;  // the item inserts a new key at the front
        logic kill;      // the entry arriving here is the evicted one
    } cell_ctrl_t;

endpackage : lkv_pkg

`default_nettype wire

/* hw/rtl/lkv_cell.sv */
// One recency slot of the LRU chain: holds an entry, compares it with the
// request key and takes its upstream neighbor's entry on a shift. Uses lkv_pkg.
`default_nettype none

module lkv_cell (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire lkv_pkg::cell_ctrl_t     ctrl,
    input  wire  [lkv_pkg::KEY_W-1:0]    req_key,
    input  wire lkv_pkg::entry_t         prev_entry,
    input  wire                          tail_in,
    input  wire  [lkv_pkg::VAL_W-1:0]    found_in,
    output lkv_pkg::entry_t              entry_out,
    output logic                         tail_out,
    output logic [lkv_pkg::VAL_W-1:0]    found_out
);
    import lkv_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             match;
    logic             take;

    assign match     = valid_reg && (key_reg == req_key);
    // The hit indication gathers from the least recent end toward the front.
    assign tail_out  = tail_in | match;
    assign found_out = found_in | (match ? value_reg : '0);
    // Cells at or in front of the hit position shift; an insert shifts all.
    assign take      = ctrl.go && (ctrl.put_miss || tail_out);

    assign entry_out = '{valid: valid_reg, key: key_reg, value: value_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= prev_entry.valid && !ctrl.kill;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

endmodule : lkv_cell

`default_nettype wire

/* hw/rtl/lru_key_value_cache.sv */
// Top level of the fully associative LRU key-value cache: a chain of
// lkv_cell slots ordered by recency, occupancy tracking and result register.
// Depends on lkv_pkg and lkv_cell.
`default_nettype none

// Usage
// Requests enter on the s_ channel (s_valid/s_ready) with s_req_type
// (0 = get, 1 = put), s_key and s_value. Each request produces exactly one
// result item on the m_ channel (m_valid/m_ready) carrying m_hit,
// m_read_value (the stored value on a get hit, otherwise 0) and m_occupancy
// (valid entries after the request).
// Entries are kept in a row of cells ordered from most recent (cell 0) to
// least recent. All cells compare the key at once; on a hit the cells in
// front of the hit shift back by one and the hit entry lands in cell 0, and
// on an inserting put the whole row shifts, dropping the least recent entry
// when the occupancy has reached the capacity in use.
// m_valid rises in the cycle after acceptance, and one item is taken per
// cycle while the receiver keeps up; the key compare across the row of cells
// is combinational and the recency shift is made as the item is accepted.
// When the receiver stalls, the result register holds and s_ready stays low until the result is taken.
// cfg_we/cfg_wdata write capacity_in_use (0 acts as 1, values above the
// store size saturate). Reset empties the cache, sets the capacity to 16
// and clears the result valid flag.

module lru_key_value_cache (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire        [lkv_pkg::CAP_W-1:0]   cfg_wdata,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_req_type,
    input  wire        [lkv_pkg::KEY_W-1:0]   s_key,
    input  wire signed [lkv_pkg::VAL_W-1:0]   s_value,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic                              m_hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  m_read_value,
    output logic       [lkv_pkg::OCC_W-1:0]   m_occupancy
);
    import lkv_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cap_sat;

    logic             m_valid_reg;
    logic             m_hit_reg;
    logic [VAL_W-1:0] m_read_value_reg;
    logic [OCC_W-1:0] m_occupancy_reg;

    logic             go;
    logic             hit;
    logic             put_miss;
    logic             evict;
    logic [VAL_W-1:0] found_value;
    entry_t           front_entry;

    entry_t           cell_entry [CAPACITY];
    logic             cell_tail  [CAPACITY+1];
    logic [VAL_W-1:0] cell_found [CAPACITY+1];
    cell_ctrl_t       cell_ctrl  [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign go      = s_valid && s_ready;

    // The gathered hit and value come out at the front of the row.
    assign hit         = cell_tail[0];
    assign found_value = cell_found[0];
    assign put_miss    = s_req_type && !hit;

    // Effective capacity: zero acts as one, anything beyond the store saturates.
    always_comb begin
        if (cap_reg == '0) begin
            cap_sat = CNT_W'(1);
        end else if (int'(cap_reg) > CAPACITY) begin
            cap_sat = CNT_W'(CAPACITY);
        end else begin
            cap_sat = CNT_W'(cap_reg);
        end
    end

    // An insert at or above capacity pushes the least recent entry out; it
    // sits at position count-1 and lands in cell count (or past the row's end), which drops it.
    assign evict      = put_miss && (count_reg >= cap_sat);
    assign count_next = count_reg + CNT_W'(put_miss && !evict);

    // The entry written into cell 0: the requested key, with the new value
    // for a put or the value that was found for a get hit.
    assign front_entry = '{
        valid: 1'b1,
        key:   s_key,
        value: s_req_type ? VAL_W'(s_value) : found_value
    };

    assign cell_tail[CAPACITY]  = 1'b0;
    assign cell_found[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign cell_ctrl[i] = '{
            go:       go,
            put_miss: put_miss,
            kill:     evict && (count_reg == CNT_W'(i))
        };

        if (i == 0) begin : g_front
            lkv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[i]),
                .req_key    (s_key),
                .prev_entry (front_entry),
                .tail_in    (cell_tail[i+1]),
                .found_in   (cell_found[i+1]),
                .entry_out  (cell_entry[i]),
                .tail_out   (cell_tail[i]),
                .found_out  (cell_found[i])
            );
        end else begin : g_rest
            lkv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[i]),
                .req_key    (s_key),
                .prev_entry (cell_entry[i-1]),
                .tail_in    (cell_tail[i+1]),
                .found_in   (cell_found[i+1]),
                .entry_out  (cell_entry[i]),
                .tail_out   (cell_tail[i]),
                .found_out  (cell_found[i])
            );
        end
    end

    // Capacity register and occupancy counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (go) begin
                count_reg <= count_next;
            end
        end
    end

    // Result register: loaded when an item is accepted, held while stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_hit_reg        <= hit;
            m_read_value_reg <= (hit && !s_req_type) ? found_value : '0;
            m_occupancy_reg  <= OCC_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;
    assign m_occupancy  = m_occupancy_reg;

endmodule : lru_key_value_cache

`default_nettype wire
